### hw/rtl/nec_ir_frame_transmitter_unit_macros.svh
// assertion macros used by the checker file of the nec ir transmitter
// no dependencies; include by bare file name
`ifndef NEC_IR_FRAME_TRANSMITTER_UNIT_MACROS_SVH
`define NEC_IR_FRAME_TRANSMITTER_UNIT_MACROS_SVH

// same-cycle implication, masked while rst is high
`define NECIR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, masked while rst is high
`define NECIR_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/necir_pkg.sv
// types and constants of the nec ir frame transmitter
// no dependencies
package necir_pkg;

   localparam int DUR_WIDTH   = 16;
   localparam int CODE_WIDTH  = 32;
   localparam int BITPOS_WIDTH = 5;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [BITPOS_WIDTH-1:0] LAST_BIT    = 5'd31;
   localparam logic [BITPOS_WIDTH-1:0] ADDR_OFFSET = 5'd16;

   localparam logic [DUR_WIDTH-1:0] RST_LEADER_MARK  = 16'd9000;
   localparam logic [DUR_WIDTH-1:0] RST_LEADER_SPACE = 16'd4500;
   localparam logic [DUR_WIDTH-1:0] RST_BIT_MARK     = 16'd560;
   localparam logic [DUR_WIDTH-1:0] RST_ZERO_SPACE   = 16'd560;
   localparam logic [DUR_WIDTH-1:0] RST_ONE_SPACE    = 16'd1690;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_LEADER_MARK  = 3'd0,
      CSR_LEADER_SPACE = 3'd1,
      CSR_BIT_MARK     = 3'd2,
      CSR_ZERO_SPACE   = 3'd3,
      CSR_ONE_SPACE    = 3'd4
   } csr_index_type;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_TICK = 1'b1
   } opcode_type;

   typedef enum logic [5:0] {
      PH_IDLE       = 6'b000001,
      PH_LEAD_MARK  = 6'b000010,
      PH_LEAD_SPACE = 6'b000100,
      PH_BIT_MARK   = 6'b001000,
      PH_BIT_SPACE  = 6'b010000,
      PH_STOP_MARK  = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [DUR_WIDTH-1:0] leader_mark_ticks;
      logic [DUR_WIDTH-1:0] leader_space_ticks;
      logic [DUR_WIDTH-1:0] bit_mark_ticks;
      logic [DUR_WIDTH-1:0] zero_space_ticks;
      logic [DUR_WIDTH-1:0] one_space_ticks;
   } cfg_type;

   typedef struct packed {
      logic                  opcode;
      logic [CODE_WIDTH-1:0] frame_code;
   } req_type;

   typedef struct packed {
      logic led_on;
      logic busy_res;
      logic frame_done;
   } rsp_type;

endpackage

### hw/rtl/necir_csr.sv
// duration register bank of the nec ir frame transmitter
// depends on necir_pkg
module necir_csr
   import necir_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [DUR_WIDTH-1:0]       csr_wdata,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_LEADER_MARK:  cfg_in.leader_mark_ticks  = csr_wdata;
            CSR_LEADER_SPACE: cfg_in.leader_space_ticks = csr_wdata;
            CSR_BIT_MARK:     cfg_in.bit_mark_ticks     = csr_wdata;
            CSR_ZERO_SPACE:   cfg_in.zero_space_ticks   = csr_wdata;
            CSR_ONE_SPACE:    cfg_in.one_space_ticks    = csr_wdata;
            // indexes past the list are dropped
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.leader_mark_ticks  <= RST_LEADER_MARK;
         cfg_ff.leader_space_ticks <= RST_LEADER_SPACE;
         cfg_ff.bit_mark_ticks     <= RST_BIT_MARK;
         cfg_ff.zero_space_ticks   <= RST_ZERO_SPACE;
         cfg_ff.one_space_ticks    <= RST_ONE_SPACE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### hw/rtl/nec_ir_frame_transmitter_unit.sv
// nec ir pulse-distance frame transmitter, top level
// depends on necir_pkg and necir_csr
//
// req channel: one transaction per item. opcode load captures frame_code and
// starts a frame when idle (ignored while a frame runs); opcode tick advances
// the frame by one tick. rsp channel: exactly one transaction per req item,
// giving led_on for that tick, busy_res after the item and frame_done on the
// tick that ends the stop mark.
// csr channel: index 0..4 selects leader mark, leader space, bit mark, zero
// space, one space duration in ticks; always ready, other indexes ignored.
// latency: the result is valid the cycle after the req transaction.
// throughput: one item per cycle; the phase counter update and the result
// both come from one short decrement/compare between state and rsp register.
// a stalled rsp holds its register; req_ready drops only while a result
// waits and rsp_ready is low, and rises again in the cycle it is taken.
// synchronous reset: idle, no result pending, durations back to defaults.
// frame: leader mark, leader space, 32 bits (address half then command half,
// each lsb first), stop mark. zero durations count as one tick.
module nec_ir_frame_transmitter_unit
   import necir_pkg::*;
#(
   parameter int TICK_COUNTER_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  req_type                    req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsp_type                    rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [DUR_WIDTH-1:0]       csr_wdata
);

   localparam int CW = TICK_COUNTER_WIDTH;
   localparam logic [32:0]   MAX_COUNT = (33'd1 << CW) - 33'd1;
   localparam logic [CW-1:0] ONE_TICK  = CW'(1);

   cfg_type                  cfg;
   phase_type                phase_ff, phase_in;
   logic [BITPOS_WIDTH-1:0]  bitpos_ff, bitpos_in;
   logic [CW-1:0]            ticks_ff, ticks_in;
   logic [CODE_WIDTH-1:0]    bits_ff, bits_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;
   logic                     req_fire;
   logic                     is_mark;
   logic                     cur_bit;

   // zero counts as one tick, long durations clip to the counter range
   function automatic logic [CW-1:0] load_count(input logic [DUR_WIDTH-1:0] dur);
      logic [32:0] ext;
      ext = {17'd0, dur};
      if (ext == 33'd0) begin
         ext = 33'd1;
      end
      if (ext > MAX_COUNT) begin
         ext = MAX_COUNT;
      end
      return ext[CW-1:0];
   endfunction

   necir_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign is_mark = (phase_ff == PH_LEAD_MARK) || (phase_ff == PH_BIT_MARK) ||
                    (phase_ff == PH_STOP_MARK);
   // address half goes out first
   assign cur_bit = bits_ff[bitpos_ff + ADDR_OFFSET];

   always_comb begin
      phase_in          = phase_ff;
      bitpos_in         = bitpos_ff;
      ticks_in          = ticks_ff;
      bits_in           = bits_ff;
      rsp_in.led_on     = 1'b0;
      rsp_in.frame_done = 1'b0;
      if (req_fire) begin
         if (req_data.opcode == OP_LOAD) begin
            if (phase_ff == PH_IDLE) begin
               bits_in   = req_data.frame_code;
               bitpos_in = '0;
               phase_in  = PH_LEAD_MARK;
               ticks_in  = load_count(cfg.leader_mark_ticks);
            end
         end else if (phase_ff != PH_IDLE) begin
            rsp_in.led_on = is_mark;
            if (ticks_ff > ONE_TICK) begin
               ticks_in = ticks_ff - ONE_TICK;
            end else begin
               unique case (phase_ff)
                  PH_LEAD_MARK: begin
                     phase_in = PH_LEAD_SPACE;
                     ticks_in = load_count(cfg.leader_space_ticks);
                  end
                  PH_LEAD_SPACE: begin
                     bitpos_in = '0;
                     phase_in  = PH_BIT_MARK;
                     ticks_in  = load_count(cfg.bit_mark_ticks);
                  end
                  PH_BIT_MARK: begin
                     phase_in = PH_BIT_SPACE;
                     ticks_in = cur_bit ? load_count(cfg.one_space_ticks)
                                        : load_count(cfg.zero_space_ticks);
                  end
                  PH_BIT_SPACE: begin
                     if (bitpos_ff == LAST_BIT) begin
                        phase_in = PH_STOP_MARK;
                     end else begin
                        bitpos_in = bitpos_ff + 5'd1;
                        phase_in  = PH_BIT_MARK;
                     end
                     ticks_in = load_count(cfg.bit_mark_ticks);
                  end
                  PH_STOP_MARK: begin
                     phase_in          = PH_IDLE;
                     bitpos_in         = '0;
                     ticks_in          = '0;
                     rsp_in.frame_done = 1'b1;
                  end
                  default: begin
                     phase_in = PH_IDLE;
                     ticks_in = '0;
                  end
               endcase
            end
         end
      end
      rsp_in.busy_res = (phase_in != PH_IDLE);
   end

   always_comb begin
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         bitpos_ff    <= '0;
         ticks_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         bitpos_ff    <= bitpos_in;
         ticks_ff     <= ticks_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bits_ff <= bits_in;
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

### hw/rtl/necir_checker.sv
// port-level checks for the nec ir frame transmitter, bound to the top level
// depends on necir_pkg and nec_ir_frame_transmitter_unit_macros.svh
`include "nec_ir_frame_transmitter_unit_macros.svh"

module necir_checker
   import necir_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a result waiting for the receiver keeps its value
   `NECIR_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result changed or dropped")

   // every accepted transaction produces a result next cycle
   `NECIR_ASSERT_NXT(a_rsp_follows, clock, reset, req_valid && req_ready, rsp_valid, "accepted transaction gave no result")

   // a load takes no time and leaves a frame running
   `NECIR_ASSERT_NXT(a_load_rsp, clock, reset, req_valid && req_ready && (req_data.opcode == OP_LOAD), !rsp_data.led_on && rsp_data.busy_res && !rsp_data.frame_done, "load result wrong")

   // the closing tick is still the stop mark and leaves the block idle
   `NECIR_ASSERT_IMP(a_done_shape, clock, reset, rsp_valid && rsp_data.frame_done, rsp_data.led_on && !rsp_data.busy_res, "frame end result wrong")

   // nothing pending right after reset
   `NECIR_ASSERT_NXT(a_reset_clear, clock, 1'b0, reset, !rsp_valid, "result valid after reset")

endmodule

bind nec_ir_frame_transmitter_unit necir_checker u_necir_checker (.*);

### tb/sv/nec_ir_frame_transmitter_unit_test.sv
// self-checking testbench of the nec ir frame transmitter: predicts led level, busy
// and frame end per item and checks every rsp transaction against it
// depends on necir_pkg and nec_ir_frame_transmitter_unit
`timescale 1ns / 100ps

module nec_ir_frame_transmitter_unit_test
   import necir_pkg::*;
();

   localparam int QUIET_LIMIT = 4000;
   localparam int HOLD_CYCLES = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [DUR_WIDTH-1:0] csr_wdata = '0;

   // items waiting for the driver and levels waiting for the dut
   req_type tx_items[$];
   rsp_type expected_levels[$];

   // shadow of the duration registers and of the frame sequencer
   cfg_type dur;
   phase_type tx_phase;
   logic [BITPOS_WIDTH-1:0] tx_bit;
   logic [DUR_WIDTH-1:0] tx_ticks;
   logic [CODE_WIDTH-1:0] tx_code;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_requests = 0;
   int holds_served = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int mismatch_count = 0;

   nec_ir_frame_transmitter_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // a zero duration still lasts one tick
   function automatic logic [DUR_WIDTH-1:0] tick_span(logic [DUR_WIDTH-1:0] d);
      return (d == '0) ? DUR_WIDTH'(1) : d;
   endfunction

   function automatic rsp_type advance_ir_frame(req_type item);
      rsp_type r;
      logic [BITPOS_WIDTH-1:0] bit_idx;
      r = '0;
      if (item.opcode == OP_LOAD) begin
         if (tx_phase == PH_IDLE) begin
            tx_code = item.frame_code;
            tx_bit = '0;
            tx_phase = PH_LEAD_MARK;
            tx_ticks = tick_span(dur.leader_mark_ticks);
         end
      end else if (tx_phase != PH_IDLE) begin
         r.led_on = (tx_phase == PH_LEAD_MARK || tx_phase == PH_BIT_MARK ||
                     tx_phase == PH_STOP_MARK);
         if (tx_ticks != '0) tx_ticks = tx_ticks - 1'b1;
         if (tx_ticks == '0) begin
            case (tx_phase)
               PH_LEAD_MARK: begin
                  tx_phase = PH_LEAD_SPACE;
                  tx_ticks = tick_span(dur.leader_space_ticks);
               end
               PH_LEAD_SPACE: begin
                  tx_bit = '0;
                  tx_phase = PH_BIT_MARK;
                  tx_ticks = tick_span(dur.bit_mark_ticks);
               end
               PH_BIT_MARK: begin
                  // address half goes first, so bit 0 of the sequence is code bit 16
                  bit_idx = tx_bit + ADDR_OFFSET;
                  tx_phase = PH_BIT_SPACE;
                  tx_ticks = tx_code[bit_idx] ? tick_span(dur.one_space_ticks)
                                              : tick_span(dur.zero_space_ticks);
               end
               PH_BIT_SPACE: begin
                  if (tx_bit >= LAST_BIT) begin
                     tx_phase = PH_STOP_MARK;
                  end else begin
                     tx_bit = tx_bit + 1'b1;
                     tx_phase = PH_BIT_MARK;
                  end
                  tx_ticks = tick_span(dur.bit_mark_ticks);
               end
               PH_STOP_MARK: begin
                  tx_phase = PH_IDLE;
                  tx_bit = '0;
                  r.frame_done = 1'b1;
               end
               default: tx_phase = PH_IDLE;
            endcase
         end
      end
      r.busy_res = (tx_phase != PH_IDLE);
      return r;
   endfunction

   // number of ticks from load to the end of the stop mark
   function automatic int frame_length(logic [CODE_WIDTH-1:0] code);
      int n;
      n = int'(tick_span(dur.leader_mark_ticks)) + int'(tick_span(dur.leader_space_ticks))
          + int'(tick_span(dur.bit_mark_ticks));
      for (int i = 0; i < CODE_WIDTH; i++)
         n += int'(tick_span(dur.bit_mark_ticks)) + (code[i] ? int'(tick_span(dur.one_space_ticks))
                                                           : int'(tick_span(dur.zero_space_ticks)));
      return n;
   endfunction

   function automatic void push_item(opcode_type op, logic [CODE_WIDTH-1:0] code);
      req_type item;
      item.opcode = op;
      item.frame_code = code;
      tx_items.push_back(item);
   endfunction

   // load plus the ticks of a whole frame; stray loads land while busy and are ignored
   function automatic int queue_frame(logic [CODE_WIDTH-1:0] code, int stray_pct);
      int span;
      span = frame_length(code);
      push_item(OP_LOAD, code);
      for (int k = 0; k < span; k++) begin
         if (k > 0 && $urandom_range(99) < stray_pct) push_item(OP_LOAD, $urandom);
         push_item(OP_TICK, $urandom);
      end
      return span + 1;
   endfunction

   task automatic queue_random_frames(int target);
      int queued;
      queued = 0;
      while (queued < target) begin
         queued += queue_frame($urandom, 6);
         repeat ($urandom_range(0, 3)) push_item(OP_TICK, $urandom);
      end
   endtask

   task automatic write_duration(logic [CSR_INDEX_WIDTH-1:0] idx, logic [DUR_WIDTH-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_LEADER_MARK:  dur.leader_mark_ticks = value;
         CSR_LEADER_SPACE: dur.leader_space_ticks = value;
         CSR_BIT_MARK:     dur.bit_mark_ticks = value;
         CSR_ZERO_SPACE:   dur.zero_space_ticks = value;
         CSR_ONE_SPACE:    dur.one_space_ticks = value;
         default: ;
      endcase
   endtask

   task automatic set_durations(logic [DUR_WIDTH-1:0] lm, logic [DUR_WIDTH-1:0] ls,
                                logic [DUR_WIDTH-1:0] bm, logic [DUR_WIDTH-1:0] zs,
                                logic [DUR_WIDTH-1:0] os);
      write_duration(CSR_LEADER_MARK, lm);
      write_duration(CSR_LEADER_SPACE, ls);
      write_duration(CSR_BIT_MARK, bm);
      write_duration(CSR_ZERO_SPACE, zs);
      write_duration(CSR_ONE_SPACE, os);
   endtask

   task automatic set_random_durations(int hi);
      set_durations(DUR_WIDTH'($urandom_range(1, hi)), DUR_WIDTH'($urandom_range(1, hi)),
                    DUR_WIDTH'($urandom_range(1, hi)), DUR_WIDTH'($urandom_range(1, hi)),
                    DUR_WIDTH'($urandom_range(1, hi)));
   endtask

   task automatic wait_drained();
      while (tx_items.size() != 0 || req_valid || expected_levels.size() != 0)
         @(posedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (tx_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_data <= tx_items.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver, with an occasional long hold-off to back up the input
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_requests != holds_served) begin
         holds_served <= holds_served + 1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // monitor and scoreboard
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_levels.size() == 0) begin
               $error("unexpected rsp transaction: %b", rsp_data);
               mismatch_count++;
            end else begin
               want = expected_levels.pop_front();
               if (rsp_data.led_on !== want.led_on) begin
                  $error("led_on: expected %0b, got %0b", want.led_on, rsp_data.led_on);
                  mismatch_count++;
               end
               if (rsp_data.busy_res !== want.busy_res) begin
                  $error("busy_res: expected %0b, got %0b", want.busy_res, rsp_data.busy_res);
                  mismatch_count++;
               end
               if (rsp_data.frame_done !== want.frame_done) begin
                  $error("frame_done: expected %0b, got %0b", want.frame_done,
                         rsp_data.frame_done);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) expected_levels.push_back(advance_ir_frame(req_data));
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("nec_ir_frame_transmitter_unit: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      dur.leader_mark_ticks = RST_LEADER_MARK;
      dur.leader_space_ticks = RST_LEADER_SPACE;
      dur.bit_mark_ticks = RST_BIT_MARK;
      dur.zero_space_ticks = RST_ZERO_SPACE;
      dur.one_space_ticks = RST_ONE_SPACE;
      tx_phase = PH_IDLE;
      tx_bit = '0;
      tx_ticks = '0;
      tx_code = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // short durations: idle tick, one frame with a load while busy, idle tick
      set_durations(16'd3, 16'd2, 16'd1, 16'd1, 16'd2);
      push_item(OP_TICK, '1);
      push_item(OP_LOAD, 32'h8000_0001);
      push_item(OP_LOAD, 32'h5A5A_A5A5);
      repeat (frame_length(32'h8000_0001)) push_item(OP_TICK, $urandom);
      push_item(OP_TICK, '0);
      wait_drained();

      // shortest durations, code extremes, many loads while busy
      set_durations(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
      void'(queue_frame('1, 0));
      void'(queue_frame('0, 50));
      push_item(OP_TICK, '1);
      wait_drained();

      // longer leader and spaces, a single one bit among zeros
      set_durations(16'd24, 16'd16, 16'd2, 16'd3, 16'd9);
      void'(queue_frame(CODE_WIDTH'(1) << $urandom_range(31), 0));
      wait_drained();

      // zero durations count as one tick; writes past the last register change nothing
      set_durations('0, '0, '0, '0, '0);
      for (int k = int'(CSR_ONE_SPACE) + 1; k < (1 << CSR_INDEX_WIDTH); k++)
         write_duration(CSR_INDEX_WIDTH'(k), DUR_WIDTH'($urandom));
      send_idle_pct = 88;
      queue_random_frames(160);
      wait_drained();

      set_random_durations(4);
      send_idle_pct = 0;
      recv_stall_pct = 88;
      queue_random_frames(160);
      wait_drained();

      set_random_durations(3);
      send_idle_pct = 14;
      recv_stall_pct = 14;
      queue_random_frames(160);
      wait_drained();

      // receiver holds off while the sender keeps offering
      set_random_durations(4);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_requests = hold_requests + 1;
      queue_random_frames(160);
      wait_drained();

      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && expected_levels.size() == 0)
         $display("nec_ir_frame_transmitter_unit: match");
      else
         $display("nec_ir_frame_transmitter_unit: mismatch");
      $finish;
   end

endmodule
